@@ sv/tssr_pkg.sv @@
// Shared types and constants of the transport-stream section reassembler.
// No dependencies; the reassembler and the context cell take names from here by scope.
package tssr_pkg;

   localparam int unsigned SLOT_BITS = 6;          // covers up to 64 contexts

   localparam logic [7:0]  PACKET_BYTES = 8'd188;
   localparam logic [7:0]  HEADER_LAST  = 8'd3;
   localparam logic [12:0] LENGTH_EXTRA = 13'd3;

   // Result event codes
   localparam logic [2:0] EV_BYTE  = 3'd0;
   localparam logic [2:0] EV_FINAL = 3'd1;
   localparam logic [2:0] EV_DROP  = 3'd2;
   localparam logic [2:0] EV_NOCTX = 3'd3;
   localparam logic [2:0] EV_FULL  = 3'd4;

   // Context update commands broadcast to the cells
   localparam logic [2:0] CMD_IDLE  = 3'd0;
   localparam logic [2:0] CMD_OPEN  = 3'd1;
   localparam logic [2:0] CMD_COUNT = 3'd2;
   localparam logic [2:0] CMD_DROP  = 3'd3;
   localparam logic [2:0] CMD_DATA  = 3'd4;
   localparam logic [2:0] CMD_CLOSE = 3'd5;

   // Lookup and selection data handed from cell to cell
   typedef struct packed {
      logic                 hit_seen;
      logic [SLOT_BITS-1:0] hit_slot;
      logic [3:0]           hit_cc;
      logic                 free_seen;
      logic [SLOT_BITS-1:0] free_slot;
      logic                 cur_valid;
      logic [12:0]          cur_fill;
      logic [12:0]          cur_length;
   } chain_type;

   // Update command for one context slot
   typedef struct packed {
      logic [2:0]           op;
      logic [SLOT_BITS-1:0] slot;
      logic [12:0]          pid;
      logic [3:0]           cc;
      logic [12:0]          fill;
      logic [12:0]          length;
   } cmd_type;

endpackage

@@ sv/tssr_channels.sv @@
// Valid/ready channel interfaces of the section reassembler.
// Depends on nothing; ts_section_reassembler takes one of each as a port.
interface tssr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ts_byte;
   logic       packet_start;

   modport source (output valid, ts_byte, packet_start, input ready);
   modport sink   (input valid, ts_byte, packet_start, output ready);
endinterface

interface tssr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [2:0]  slot;
   logic [12:0] stream_pid;
   logic [12:0] section_offset;
   logic [7:0]  data_byte;
   logic [12:0] section_length;

   modport source (output valid, event_res, slot, stream_pid, section_offset,
                   data_byte, section_length, input ready);
   modport sink   (input valid, event_res, slot, stream_pid, section_offset,
                   data_byte, section_length, output ready);
endinterface

@@ sv/ts_section_reassembler.sv @@
// Transport-stream section reassembler, one packet byte per transaction.
// A result enters the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle if not stalled; the PID lookup ripples through the row
// of context cells within that cycle, so CONTEXTS sets the length of the critical path.
// Reset (synchronous, active high) closes every context and restarts packet parsing;
// context payload registers are not cleared and are only read once their slot is open.
module ts_section_reassembler #(
   parameter int unsigned CONTEXTS = 8
) (
   input  logic  clock,
   input  logic  reset,
   tssr_req_if.sink   req_if,
   tssr_rsp_if.source rsp_if
);

   // Packet parse state
   logic [7:0]                      byte_position_ff, byte_position_in;
   logic [31:0]                     header_hold_ff, header_hold_in;
   logic                            packet_accepted_ff, packet_accepted_in;
   logic [tssr_pkg::SLOT_BITS-1:0]  current_slot_ff, current_slot_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  event_ff, event_in;
   logic [2:0]  slot_ff, slot_in;
   logic [12:0] pid_ff, pid_in;
   logic [12:0] offset_ff, offset_in;
   logic [7:0]  data_ff, data_in;
   logic [12:0] length_ff, length_in;

   logic                  accept;
   logic                  emit;
   logic [7:0]            idx;
   logic                  start_flag;
   logic [3:0]            cc_rx;
   logic [3:0]            cc_next;
   logic [12:0]           hdr_pid;
   logic [12:0]           new_length;
   logic [12:0]           sec_length;
   logic                  fin;
   tssr_pkg::cmd_type     cmd;
   tssr_pkg::chain_type   chain [CONTEXTS+1];

   // Take a new transaction whenever the output register is free or draining
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // Header bytes 0..2 sit in the low 24 bits when byte 3 arrives
   assign hdr_pid    = header_hold_ff[12:0];
   assign start_flag = header_hold_ff[14];
   assign cc_rx      = req_if.ts_byte[3:0];
   assign cc_next    = 4'(cc_rx + 4'd1);

   assign chain[0] = '0;

   for (genvar i = 0; i < CONTEXTS; i++) begin : g_cell
      tssr_ctx_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .hdr_pid   (hdr_pid),
         .cur_slot  (current_slot_ff),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   // Section length: high nibble at offset 1, low byte plus header at offset 2
   always_comb begin
      new_length = chain[CONTEXTS].cur_length;
      if (chain[CONTEXTS].cur_fill == 13'd1) begin
         new_length = {1'b0, req_if.ts_byte[3:0], 8'h00};
      end else if (chain[CONTEXTS].cur_fill == 13'd2) begin
         new_length = 13'(chain[CONTEXTS].cur_length + 13'(req_if.ts_byte)
                          + tssr_pkg::LENGTH_EXTRA);
      end
      sec_length = (chain[CONTEXTS].cur_fill >= 13'd2) ? new_length : 13'd0;
      fin = (chain[CONTEXTS].cur_fill >= 13'd2)
            && ((14'(chain[CONTEXTS].cur_fill) + 14'd1) >= 14'(sec_length));
   end

   always_comb begin
      idx                = req_if.packet_start ? 8'd0 : byte_position_ff;
      byte_position_in   = byte_position_ff;
      header_hold_in     = header_hold_ff;
      packet_accepted_in = packet_accepted_ff;
      current_slot_in    = current_slot_ff;
      cmd                = '0;
      cmd.op             = tssr_pkg::CMD_IDLE;
      cmd.pid            = hdr_pid;
      cmd.cc             = cc_next;
      emit               = 1'b0;
      event_in           = tssr_pkg::EV_BYTE;
      slot_in            = '0;
      pid_in             = hdr_pid;
      offset_in          = '0;
      data_in            = '0;
      length_in          = '0;

      if (accept) begin
         if (req_if.packet_start) begin
            packet_accepted_in = 1'b0;
         end
         if (idx >= tssr_pkg::PACKET_BYTES) begin
            // Long packet: hold the position and drop the byte
            byte_position_in = tssr_pkg::PACKET_BYTES;
         end else if (idx <= tssr_pkg::HEADER_LAST) begin
            byte_position_in = 8'(idx + 8'd1);
            header_hold_in   = (idx == 8'd0) ? {24'd0, req_if.ts_byte}
                                             : {header_hold_ff[23:0], req_if.ts_byte};
            if (idx == tssr_pkg::HEADER_LAST) begin
               packet_accepted_in = 1'b0;
               if (start_flag) begin
                  if (chain[CONTEXTS].hit_seen || chain[CONTEXTS].free_seen) begin
                     // Reopen the matching context, else open the lowest free slot
                     cmd.op = tssr_pkg::CMD_OPEN;
                     cmd.slot = chain[CONTEXTS].hit_seen ? chain[CONTEXTS].hit_slot
                                                         : chain[CONTEXTS].free_slot;
                     packet_accepted_in = 1'b1;
                     current_slot_in    = cmd.slot;
                  end else begin
                     emit     = 1'b1;
                     event_in = tssr_pkg::EV_FULL;
                  end
               end else if (!chain[CONTEXTS].hit_seen) begin
                  emit     = 1'b1;
                  event_in = tssr_pkg::EV_NOCTX;
               end else if (chain[CONTEXTS].hit_cc == cc_rx) begin
                  cmd.op             = tssr_pkg::CMD_COUNT;
                  cmd.slot           = chain[CONTEXTS].hit_slot;
                  packet_accepted_in = 1'b1;
                  current_slot_in    = chain[CONTEXTS].hit_slot;
               end else begin
                  // Continuity break: drop the context
                  cmd.op   = tssr_pkg::CMD_DROP;
                  cmd.slot = chain[CONTEXTS].hit_slot;
                  emit     = 1'b1;
                  event_in = tssr_pkg::EV_DROP;
                  slot_in  = chain[CONTEXTS].hit_slot[2:0];
               end
            end
         end else begin
            byte_position_in = 8'(idx + 8'd1);
            if (packet_accepted_ff) begin
               if (!chain[CONTEXTS].cur_valid) begin
                  packet_accepted_in = 1'b0;
               end else begin
                  cmd.op     = fin ? tssr_pkg::CMD_CLOSE : tssr_pkg::CMD_DATA;
                  cmd.slot   = current_slot_ff;
                  cmd.fill   = 13'(chain[CONTEXTS].cur_fill + 13'd1);
                  cmd.length = new_length;
                  emit       = 1'b1;
                  event_in   = fin ? tssr_pkg::EV_FINAL : tssr_pkg::EV_BYTE;
                  slot_in    = current_slot_ff[2:0];
                  pid_in     = header_hold_ff[20:8];
                  offset_in  = chain[CONTEXTS].cur_fill;
                  data_in    = req_if.ts_byte;
                  length_in  = sec_length;
                  if (fin) begin
                     packet_accepted_in = 1'b0;
                  end
               end
            end
         end
      end

      // Advance the output register: load on a result, clear once taken
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff   <= '0;
         header_hold_ff     <= '0;
         packet_accepted_ff <= 1'b0;
         current_slot_ff    <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         byte_position_ff   <= byte_position_in;
         header_hold_ff     <= header_hold_in;
         packet_accepted_ff <= packet_accepted_in;
         current_slot_ff    <= current_slot_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Payload of the output register; load only with a new result
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         event_ff  <= event_in;
         slot_ff   <= slot_in;
         pid_ff    <= pid_in;
         offset_ff <= offset_in;
         data_ff   <= data_in;
         length_ff <= length_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.event_res      = event_ff;
   assign rsp_if.slot           = slot_ff;
   assign rsp_if.stream_pid     = pid_ff;
   assign rsp_if.section_offset = offset_ff;
   assign rsp_if.data_byte      = data_ff;
   assign rsp_if.section_length = length_ff;

endmodule

@@ sv/tssr_ctx_cell.sv @@
// One section context slot of the reassembler: holds PID, counter, length, fill.
// Depends on tssr_pkg; chained by ts_section_reassembler.
module tssr_ctx_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [12:0]                         hdr_pid,
   input  logic [tssr_pkg::SLOT_BITS-1:0]      cur_slot,
   input  tssr_pkg::cmd_type                   cmd,
   input  tssr_pkg::chain_type                 chain_in,
   output tssr_pkg::chain_type                 chain_out
);

   localparam logic [tssr_pkg::SLOT_BITS-1:0] MY_SLOT = tssr_pkg::SLOT_BITS'(INDEX);

   logic        valid_ff, valid_in;
   logic [12:0] pid_ff, pid_in;
   logic [3:0]  cc_ff, cc_in;
   logic [12:0] length_ff, length_in;
   logic [12:0] fill_ff, fill_in;
   logic        hit;
   logic        mine;

   assign hit  = valid_ff && (pid_ff == hdr_pid);
   assign mine = (cmd.slot == MY_SLOT);

   // Lowest match and lowest free slot win: pass on what is already found
   always_comb begin
      chain_out = chain_in;
      if (hit && !chain_in.hit_seen) begin
         chain_out.hit_seen = 1'b1;
         chain_out.hit_slot = MY_SLOT;
         chain_out.hit_cc   = cc_ff;
      end
      if (!valid_ff && !chain_in.free_seen) begin
         chain_out.free_seen = 1'b1;
         chain_out.free_slot = MY_SLOT;
      end
      if (cur_slot == MY_SLOT) begin
         chain_out.cur_valid  = valid_ff;
         chain_out.cur_fill   = fill_ff;
         chain_out.cur_length = length_ff;
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      pid_in    = pid_ff;
      cc_in     = cc_ff;
      length_in = length_ff;
      fill_in   = fill_ff;
      if (mine) begin
         case (cmd.op)
            tssr_pkg::CMD_OPEN: begin
               valid_in  = 1'b1;
               pid_in    = cmd.pid;
               cc_in     = cmd.cc;
               length_in = '0;
               fill_in   = '0;
            end
            tssr_pkg::CMD_COUNT: begin
               cc_in = cmd.cc;
            end
            tssr_pkg::CMD_DROP: begin
               valid_in = 1'b0;
            end
            tssr_pkg::CMD_DATA: begin
               length_in = cmd.length;
               fill_in   = cmd.fill;
            end
            tssr_pkg::CMD_CLOSE: begin
               valid_in  = 1'b0;
               length_in = cmd.length;
               fill_in   = cmd.fill;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff    <= pid_in;
      cc_ff     <= cc_in;
      length_ff <= length_in;
      fill_ff   <= fill_in;
   end

endmodule
